/* design/svp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the space vector PWM sector and compare core.
// No dependencies; every other design file refers to this package by scoped names.
package svp_pkg;

    localparam int CNT_W = 16;                        // timer count width
    localparam int BUS_W = 15;                        // bus voltage register width
    localparam int CFG_W = (CNT_W > BUS_W) ? CNT_W : BUS_W;
    localparam int V_W   = 16;                        // alpha/beta voltage width
    localparam int P_W   = 34;                        // projection numerators nX, nY, nZ
    localparam int D_W   = BUS_W + 15;                // bus voltage in Q15
    localparam int N_W   = 37;                        // signed phase time numerators
    localparam int Q_W   = 35;                        // unsigned numerator and 4E

    // Q15 constants: root 3, root 3 over 2, three halves and one half.
    localparam logic signed [P_W-1:0] K_SQRT3   = P_W'(56756);
    localparam logic signed [P_W-1:0] K_SQRT3_2 = P_W'(28378);
    localparam logic signed [P_W-1:0] K_THREE_2 = P_W'(49152);
    localparam logic signed [P_W-1:0] K_HALF    = P_W'(16384);

    localparam logic [BUS_W-1:0] BUS_RESET    = BUS_W'(2400);
    localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(4200);

    typedef enum logic [0:0] {
        CFG_BUS_VOLTAGE = 1'b0,
        CFG_PWM_PERIOD  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_ZERO  = 3'd0,
        SEC_1     = 3'd1,
        SEC_2     = 3'd2,
        SEC_3     = 3'd3,
        SEC_4     = 3'd4,
        SEC_5     = 3'd5,
        SEC_6     = 3'd6,
        SEC_SEVEN = 3'd7
    } t_sector;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_FULL = 2'd1,
        MODE_DIV  = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [V_W-1:0] v_alpha;
        logic signed [V_W-1:0] v_beta;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] compare_a;
        logic [CNT_W-1:0] compare_b;
        logic [CNT_W-1:0] compare_c;
        logic [2:0]       sector;
        logic             overmodulated;
    } t_out;

    typedef struct packed {
        t_mode          mode;
        logic [Q_W-1:0] num;
    } t_lane_cmd;

    typedef struct packed {
        logic             valid;
        t_sector          sector;
        logic             ovm;
        logic [CNT_W-1:0] period;
    } t_side;

    typedef struct packed {
        t_side          side;
        logic [Q_W-1:0] den;
        t_lane_cmd      cmd_a;
        t_lane_cmd      cmd_b;
        t_lane_cmd      cmd_c;
    } t_front;

endpackage

/* design/svpwm_sector_and_compare_core.sv */
`timescale 1ns / 1ps
// Top level of the space vector PWM sector and compare core: configuration
// registers, the front end, three compare lanes and the output register. Uses svp_pkg.
//
// Usage:
//   Input channel: i_valid / i_data (v_alpha, v_beta) with o_stall back to the
//   sender; a transaction completes when i_valid is high and o_stall is low.
//   Output channel: o_valid / o_data (three compares, sector, overmodulated)
//   with i_stall from the receiver.
//   Configuration: i_cfg_we writes i_cfg_data to the register i_cfg_idx
//   (bus voltage or PWM period). Write only while no transaction is in flight.
//   Throughput: one transaction per cycle unless the receiver stalls. Pipeline:
//   3 front-end stages, one long-division stage per timer count bit (16), and
//   the output register; the division pipeline sets most of this depth.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   o_stall rises in the same cycle, so nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits and loads the
//   default bus voltage of 2400 and period of 4200.
module svpwm_sector_and_compare_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  svp_pkg::t_in              i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output svp_pkg::t_out             o_data,
    input  logic                      i_cfg_we,
    input  svp_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [svp_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int S = svp_pkg::CNT_W;

    logic [svp_pkg::BUS_W-1:0] r_bus;
    logic [svp_pkg::CNT_W-1:0] r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus    <= svp_pkg::BUS_RESET;
            r_period <= svp_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svp_pkg::CFG_BUS_VOLTAGE: r_bus    <= i_cfg_data[svp_pkg::BUS_W-1:0];
                svp_pkg::CFG_PWM_PERIOD:  r_period <= i_cfg_data[svp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    svp_pkg::t_front front;

    svp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_bus    (r_bus),
        .i_period (r_period),
        .o_front  (front)
    );

    logic [S-1:0] q_a, q_b, q_c;

    svp_lane u_lane_a (
        .i_clk (i_clk), .i_en (en), .i_cmd (front.cmd_a), .i_den (front.den),
        .i_period (front.side.period), .o_q (q_a)
    );
    svp_lane u_lane_b (
        .i_clk (i_clk), .i_en (en), .i_cmd (front.cmd_b), .i_den (front.den),
        .i_period (front.side.period), .o_q (q_b)
    );
    svp_lane u_lane_c (
        .i_clk (i_clk), .i_en (en), .i_cmd (front.cmd_c), .i_den (front.den),
        .i_period (front.side.period), .o_q (q_c)
    );

    // Sector, flag and period ride alongside the division stages.
    svp_pkg::t_side r_side [S];

    for (genvar k = 0; k < S; k++) begin : g_side
        svp_pkg::t_side side_in;
        assign side_in = (k == 0) ? front.side : r_side[(k == 0) ? 0 : k-1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (en) begin
                r_side[k].valid <= side_in.valid;
            end
            if (en) begin
                r_side[k].sector <= side_in.sector;
                r_side[k].ovm    <= side_in.ovm;
                r_side[k].period <= side_in.period;
            end
        end
    end

    svp_pkg::t_side last;
    svp_pkg::t_out  n_out;
    logic [S-1:0]   quarter;

    always_comb begin
        last          = r_side[S-1];
        quarter       = last.period >> 2;
        n_out.sector  = last.sector;
        n_out.overmodulated = last.ovm;
        unique case (last.sector)
            svp_pkg::SEC_1: begin
                n_out.compare_a = q_b; n_out.compare_b = q_a; n_out.compare_c = q_c;
            end
            svp_pkg::SEC_2: begin
                n_out.compare_a = q_a; n_out.compare_b = q_c; n_out.compare_c = q_b;
            end
            svp_pkg::SEC_3: begin
                n_out.compare_a = q_a; n_out.compare_b = q_b; n_out.compare_c = q_c;
            end
            svp_pkg::SEC_4: begin
                n_out.compare_a = q_c; n_out.compare_b = q_b; n_out.compare_c = q_a;
            end
            svp_pkg::SEC_5: begin
                n_out.compare_a = q_c; n_out.compare_b = q_a; n_out.compare_c = q_b;
            end
            svp_pkg::SEC_6: begin
                n_out.compare_a = q_b; n_out.compare_b = q_c; n_out.compare_c = q_a;
            end
            default: begin
                n_out.compare_a = quarter; n_out.compare_b = quarter;
                n_out.compare_c = quarter;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= last.valid;
        end
        if (en) begin
            o_data <= n_out;
        end
    end

endmodule

/* design/svp_front.sv */
`timescale 1ns / 1ps
// Front end: sector detection, active time numerators, overmodulation and
// per-phase numerator classification in three register stages. Uses svp_pkg.
module svp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  svp_pkg::t_in                   i_data,
    input  logic [svp_pkg::BUS_W-1:0]      i_bus,
    input  logic [svp_pkg::CNT_W-1:0]      i_period,
    output svp_pkg::t_front                o_front
);

    // Stage 1: projections and sector.
    logic signed [svp_pkg::P_W-1:0] a_x, b_x, n_nx, n_ny, n_nz, u2, u3;
    logic [svp_pkg::BUS_W-1:0]      vdc;
    svp_pkg::t_sector               n_sec1;

    logic                           r_v1;
    svp_pkg::t_sector               r_sec1;
    logic signed [svp_pkg::P_W-1:0] r_nx, r_ny, r_nz;
    logic [svp_pkg::D_W-1:0]        r_d1;
    logic [svp_pkg::CNT_W-1:0]      r_t1;

    always_comb begin
        a_x    = svp_pkg::P_W'(i_data.v_alpha);
        b_x    = svp_pkg::P_W'(i_data.v_beta);
        n_nx   = b_x * svp_pkg::K_SQRT3;
        n_ny   = a_x * svp_pkg::K_THREE_2 + b_x * svp_pkg::K_SQRT3_2;
        n_nz   = b_x * svp_pkg::K_SQRT3_2 - a_x * svp_pkg::K_THREE_2;
        u2     = a_x * svp_pkg::K_SQRT3_2 - b_x * svp_pkg::K_HALF;
        u3     = -(a_x * svp_pkg::K_SQRT3_2) - b_x * svp_pkg::K_HALF;
        n_sec1 = svp_pkg::t_sector'({u3 > 0, u2 > 0, b_x > 0});
        vdc    = (i_bus == '0) ? svp_pkg::BUS_W'(1) : i_bus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_sec1 <= n_sec1;
            r_nx   <= n_nx;
            r_ny   <= n_ny;
            r_nz   <= n_nz;
            r_d1   <= {vdc, 15'b0};
            r_t1   <= i_period;
        end
    end

    // Stage 2: active time pick and overmodulation test.
    logic signed [svp_pkg::P_W-1:0] n_n1, n_n2, n_sum, n_e, d_x;
    logic                           n_ovm;

    logic                           r_v2;
    svp_pkg::t_sector               r_sec2;
    logic signed [svp_pkg::P_W-1:0] r_n1, r_n2, r_e;
    logic                           r_ovm2;
    logic [svp_pkg::CNT_W-1:0]      r_t2;

    always_comb begin
        n_n1 = '0;
        n_n2 = '0;
        unique case (r_sec1)
            svp_pkg::SEC_1: begin n_n1 = r_nz;  n_n2 = r_ny;  end
            svp_pkg::SEC_2: begin n_n1 = r_ny;  n_n2 = -r_nx; end
            svp_pkg::SEC_3: begin n_n1 = -r_nz; n_n2 = r_nx;  end
            svp_pkg::SEC_4: begin n_n1 = -r_nx; n_n2 = r_nz;  end
            svp_pkg::SEC_5: begin n_n1 = r_nx;  n_n2 = -r_ny; end
            svp_pkg::SEC_6: begin n_n1 = -r_ny; n_n2 = -r_nz; end
            default: begin n_n1 = '0; n_n2 = '0; end
        endcase
        d_x   = svp_pkg::P_W'(r_d1);
        n_sum = n_n1 + n_n2;
        // Sector codes 0 and 7 select no times, so the sum is zero and never wins.
        n_ovm = (r_t1 != '0) && (n_sum > d_x);
        n_e   = n_ovm ? n_sum : d_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_sec2 <= r_sec1;
            r_n1   <= n_n1;
            r_n2   <= n_n2;
            r_e    <= n_e;
            r_ovm2 <= n_ovm;
            r_t2   <= r_t1;
        end
    end

    // Stage 3: phase numerators against the common denominator 4E.
    logic signed [svp_pkg::N_W-1:0] e_x, n1_x, n2_x, na, nb, nc, den_x;
    logic [svp_pkg::Q_W-1:0]        n_den;
    svp_pkg::t_lane_cmd             n_cmd_a, n_cmd_b, n_cmd_c;

    function automatic svp_pkg::t_lane_cmd classify(
        input logic signed [svp_pkg::N_W-1:0] num,
        input logic signed [svp_pkg::N_W-1:0] den
    );
        svp_pkg::t_lane_cmd c;
        c.num = num[svp_pkg::Q_W-1:0];
        if (num <= 0) begin
            c.mode = svp_pkg::MODE_ZERO;
        end else if (num >= den) begin
            c.mode = svp_pkg::MODE_FULL;
        end else begin
            c.mode = svp_pkg::MODE_DIV;
        end
        return c;
    endfunction

    always_comb begin
        e_x     = svp_pkg::N_W'(r_e);
        n1_x    = svp_pkg::N_W'(r_n1);
        n2_x    = svp_pkg::N_W'(r_n2);
        na      = e_x - n1_x - n2_x;
        nb      = e_x + n1_x - n2_x;
        nc      = e_x + n1_x + n2_x;
        // E is positive and below 2^33, so 4E fits the unsigned width.
        n_den   = {r_e[svp_pkg::Q_W-3:0], 2'b00};
        den_x   = $signed({2'b00, n_den});
        n_cmd_a = classify(na, den_x);
        n_cmd_b = classify(nb, den_x);
        n_cmd_c = classify(nc, den_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_front.side.valid <= 1'b0;
        end else if (i_en) begin
            o_front.side.valid <= r_v2;
        end
        if (i_en) begin
            o_front.side.sector <= r_sec2;
            o_front.side.ovm    <= r_ovm2;
            o_front.side.period <= r_t2;
            o_front.den         <= n_den;
            o_front.cmd_a       <= n_cmd_a;
            o_front.cmd_b       <= n_cmd_b;
            o_front.cmd_c       <= n_cmd_c;
        end
    end

endmodule

/* design/svp_lane.sv */
`timescale 1ns / 1ps
// One compare lane: floor(T * num / den) by a pipelined long division that
// takes one period bit per stage, then the clamp to 0..T. Uses svp_pkg.
module svp_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  svp_pkg::t_lane_cmd        i_cmd,
    input  logic [svp_pkg::Q_W-1:0]   i_den,
    input  logic [svp_pkg::CNT_W-1:0] i_period,
    output logic [svp_pkg::CNT_W-1:0] o_q
);

    localparam int S = svp_pkg::CNT_W;
    localparam int R_W = svp_pkg::Q_W + 2;

    logic [svp_pkg::Q_W-1:0] r_rem [S];
    logic [S-1:0]            r_q   [S];
    logic [svp_pkg::Q_W-1:0] r_num [S];
    logic [svp_pkg::Q_W-1:0] r_den [S];
    logic [S-1:0]            r_t   [S];
    svp_pkg::t_mode          r_mode[S];

    for (genvar k = 0; k < S; k++) begin : g_stage
        logic [svp_pkg::Q_W-1:0] rem_in, num_in, den_in, n_rem;
        logic [S-1:0]            q_in, t_in, n_q;
        svp_pkg::t_mode          mode_in;
        logic [R_W-1:0]          acc, den1, den2;

        always_comb begin
            if (k == 0) begin
                rem_in  = '0;
                q_in    = '0;
                num_in  = i_cmd.num;
                den_in  = i_den;
                t_in    = i_period;
                mode_in = i_cmd.mode;
            end else begin
                rem_in  = r_rem[(k == 0) ? 0 : k-1];
                q_in    = r_q[(k == 0) ? 0 : k-1];
                num_in  = r_num[(k == 0) ? 0 : k-1];
                den_in  = r_den[(k == 0) ? 0 : k-1];
                t_in    = r_t[(k == 0) ? 0 : k-1];
                mode_in = r_mode[(k == 0) ? 0 : k-1];
            end
            // The remainder stays below den, so one step yields a digit of 0, 1 or 2.
            acc  = {1'b0, rem_in, 1'b0} + (t_in[S-1-k] ? {2'b00, num_in} : '0);
            den1 = {2'b00, den_in};
            den2 = {1'b0, den_in, 1'b0};
            if (acc >= den2) begin
                n_rem = svp_pkg::Q_W'(acc - den2);
                n_q   = {q_in[S-2:0], 1'b0} + S'(2);
            end else if (acc >= den1) begin
                n_rem = svp_pkg::Q_W'(acc - den1);
                n_q   = {q_in[S-2:0], 1'b1};
            end else begin
                n_rem = acc[svp_pkg::Q_W-1:0];
                n_q   = {q_in[S-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_num[k]  <= num_in;
                r_den[k]  <= den_in;
                r_t[k]    <= t_in;
                r_mode[k] <= mode_in;
            end
        end
    end

    always_comb begin
        unique case (r_mode[S-1])
            svp_pkg::MODE_ZERO: o_q = '0;
            svp_pkg::MODE_FULL: o_q = r_t[S-1];
            svp_pkg::MODE_DIV:  o_q = r_q[S-1];
            default:            o_q = '0;
        endcase
    end

endmodule

/* design/svp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the space vector PWM sector and compare core,
// attached to the top level by the bind statement below. Uses svp_pkg.
module svp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input svp_pkg::t_out o_data
);

    // The input side only backs up because a finished result is held.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stall raised without a held result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.sector == svp_pkg::SEC_ZERO ||
                     o_data.sector == svp_pkg::SEC_SEVEN))
        |-> (!o_data.overmodulated && o_data.compare_a == o_data.compare_b &&
             o_data.compare_b == o_data.compare_c))
        else $error("zero vector result is not uniform");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind svpwm_sector_and_compare_core svp_checker u_svp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

/* bench/svpwm_sector_and_compare_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for svpwm_sector_and_compare_core: a queue-fed driver, a stall
// generator and a monitor that checks every result against an exact integer predictor.
// Depends on svp_pkg and the core itself.
module svpwm_sector_and_compare_core_tb;

    localparam int DRAIN_CYCLES = 25;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    svp_pkg::t_in                  i_data = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    svp_pkg::t_out                 o_data;
    logic                          i_cfg_we = 1'b0;
    svp_pkg::t_cfg_idx             i_cfg_idx = svp_pkg::CFG_BUS_VOLTAGE;
    logic [svp_pkg::CFG_W-1:0]     i_cfg_data = '0;

    svp_pkg::t_in                  vector_q[$];
    svp_pkg::t_out                 compare_q[$];
    logic [svp_pkg::BUS_W-1:0]     bus_setting = svp_pkg::BUS_RESET;
    logic [svp_pkg::CNT_W-1:0]     period_setting = svp_pkg::PERIOD_RESET;
    bit                            gaps_on = 1'b1;
    int                            err_count = 0;
    int                            checked = 0;
    int                            settings_run = 0;
    int                            send_gap = 0;
    int                            stall_run = 0;

    svpwm_sector_and_compare_core dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 19);
        if (!gaps_on || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Truncated T * num / den, clamped to 0..T.
    function automatic longint phase_count(longint t, longint num, longint den);
        if (num <= 0) return 0;
        if (num >= den) return t;
        return (t * num) / den;
    endfunction

    function automatic svp_pkg::t_out predict_compares(svp_pkg::t_in v);
        longint a, b, t, d, u2, u3, nx, ny, nz, n1, n2, e, ta, tb, tc;
        logic [2:0] s;
        svp_pkg::t_out r;
        a = v.v_alpha;
        b = v.v_beta;
        t = period_setting;
        d = ((bus_setting == 0) ? 1 : longint'(bus_setting)) * 32768;
        u2 = a * 28378 - b * 16384;
        u3 = -a * 28378 - b * 16384;
        s = {u3 > 0, u2 > 0, b > 0};
        nx = b * 56756;
        ny = a * 49152 + b * 28378;
        nz = -a * 49152 + b * 28378;
        n1 = 0;
        n2 = 0;
        case (svp_pkg::t_sector'(s))
            svp_pkg::SEC_1: begin n1 = nz;  n2 = ny;  end
            svp_pkg::SEC_2: begin n1 = ny;  n2 = -nx; end
            svp_pkg::SEC_3: begin n1 = -nz; n2 = nx;  end
            svp_pkg::SEC_4: begin n1 = -nx; n2 = nz;  end
            svp_pkg::SEC_5: begin n1 = nx;  n2 = -ny; end
            svp_pkg::SEC_6: begin n1 = -ny; n2 = -nz; end
            default: ;
        endcase
        r = '0;
        r.sector = s;
        if (svp_pkg::t_sector'(s) == svp_pkg::SEC_ZERO ||
            svp_pkg::t_sector'(s) == svp_pkg::SEC_SEVEN) begin
            r.compare_a = svp_pkg::CNT_W'(t / 4);
            r.compare_b = svp_pkg::CNT_W'(t / 4);
            r.compare_c = svp_pkg::CNT_W'(t / 4);
            return r;
        end
        e = d;
        if (t > 0 && n1 + n2 > d) begin
            e = n1 + n2;
            r.overmodulated = 1'b1;
        end
        ta = phase_count(t, e - n1 - n2, 4 * e);
        tb = phase_count(t, e + n1 - n2, 4 * e);
        tc = phase_count(t, e + n1 + n2, 4 * e);
        case (svp_pkg::t_sector'(s))
            svp_pkg::SEC_1:
                {r.compare_a, r.compare_b, r.compare_c} = {tb[15:0], ta[15:0], tc[15:0]};
            svp_pkg::SEC_2:
                {r.compare_a, r.compare_b, r.compare_c} = {ta[15:0], tc[15:0], tb[15:0]};
            svp_pkg::SEC_3:
                {r.compare_a, r.compare_b, r.compare_c} = {ta[15:0], tb[15:0], tc[15:0]};
            svp_pkg::SEC_4:
                {r.compare_a, r.compare_b, r.compare_c} = {tc[15:0], tb[15:0], ta[15:0]};
            svp_pkg::SEC_5:
                {r.compare_a, r.compare_b, r.compare_c} = {tc[15:0], ta[15:0], tb[15:0]};
            default:
                {r.compare_a, r.compare_b, r.compare_c} = {tb[15:0], tc[15:0], ta[15:0]};
        endcase
        return r;
    endfunction

    // Driver: records the expectation when a transaction is taken, then
    // presents the next vector or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            bit taken;
            taken = i_valid && !o_stall;
            if (taken) begin
                compare_q.push_back(predict_compares(i_data));
                void'(vector_q.pop_front());
            end
            if (!i_valid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (vector_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data <= vector_q[0];
                    send_gap = draw_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            stall_run = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (compare_q.size() == 0) begin
                $error("result with nothing expected: %p", o_data);
                err_count++;
            end else begin
                svp_pkg::t_out exp_r;
                exp_r = compare_q.pop_front();
                checked++;
                if (o_data.compare_a !== exp_r.compare_a) begin
                    $error("compare_a expected %0d got %0d", exp_r.compare_a, o_data.compare_a);
                    err_count++;
                end
                if (o_data.compare_b !== exp_r.compare_b) begin
                    $error("compare_b expected %0d got %0d", exp_r.compare_b, o_data.compare_b);
                    err_count++;
                end
                if (o_data.compare_c !== exp_r.compare_c) begin
                    $error("compare_c expected %0d got %0d", exp_r.compare_c, o_data.compare_c);
                    err_count++;
                end
                if (o_data.sector !== exp_r.sector) begin
                    $error("sector expected %0d got %0d", exp_r.sector, o_data.sector);
                    err_count++;
                end
                if (o_data.overmodulated !== exp_r.overmodulated) begin
                    $error("overmodulated expected %0d got %0d",
                           exp_r.overmodulated, o_data.overmodulated);
                    err_count++;
                end
            end
        end
    end

    task automatic write_reg(svp_pkg::t_cfg_idx idx, logic [svp_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == svp_pkg::CFG_BUS_VOLTAGE) bus_setting = value[svp_pkg::BUS_W-1:0];
        else period_setting = value[svp_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (vector_q.size() > 0 || compare_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_vector(int a, int b);
        svp_pkg::t_in v;
        v.v_alpha = a;
        v.v_beta = b;
        vector_q.push_back(v);
    endtask

    task automatic add_random(int count);
        int kind;
        int mag;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                add_vector($urandom, $urandom);
            end else begin
                // Mostly vectors near the bus voltage so both linear and
                // overmodulated operation show up.
                mag = (kind < 8) ? 2 * bus_setting + 2 : 16;
                if (mag > 32767) mag = 32767;
                add_vector($urandom_range(0, 2 * mag) - mag, $urandom_range(0, 2 * mag) - mag);
            end
        end
    endtask

    initial begin
        int buses[7];
        int periods[7];
        buses   = '{2400, 1, 32767, 0, 300, 32767, 1};
        periods = '{4200, 65535, 1, 0, 1000, 65535, 1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero vector, extremes, axes and sector boundaries, one per sector.
        add_vector(0, 0);
        add_vector(32767, 32767);
        add_vector(-32768, -32768);
        add_vector(32767, -32768);
        add_vector(-32768, 32767);
        add_vector(1, 0);
        add_vector(-1, 0);
        add_vector(0, 1);
        add_vector(0, -1);
        add_vector(1000, 577);
        add_vector(1000, -577);
        add_vector(1000, 300);
        add_vector(0, 1500);
        add_vector(-1000, 300);
        add_vector(-1000, -300);
        add_vector(0, -1500);
        add_vector(1000, -300);
        add_vector(30000, 5000);
        add_vector(-20000, 20000);
        add_vector(2000, -3000);
        add_random(80);
        wait_idle();
        settings_run++;

        for (int p = 1; p < 7; p++) begin
            write_reg(svp_pkg::CFG_BUS_VOLTAGE, buses[p]);
            write_reg(svp_pkg::CFG_PWM_PERIOD, periods[p]);
            @(negedge i_clk);
            gaps_on = (p != 2);
            add_random(100);
            wait_idle();
            settings_run++;
        end

        $display("Checked %0d transactions across %0d bus voltage and period settings.",
                 checked, settings_run);
        if (err_count == 0 && compare_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
design/svp_pkg.sv
design/svp_front.sv
design/svp_lane.sv
design/svpwm_sector_and_compare_core.sv
design/svp_checker.sv
bench/svpwm_sector_and_compare_core_tb.sv
